[sv/xpbd_distance_constraint_macros.svh]
// assertion macros for the xpbd distance constraint block
// no dependencies; taken in by include where assertions are written
`ifndef XPBD_DISTANCE_CONSTRAINT_MACROS_SVH
`define XPBD_DISTANCE_CONSTRAINT_MACROS_SVH
`ifndef SYNTH
// concurrent check on an explicit clock and reset
`define XPBD_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("xpbd distance constraint check failed");
// concurrent check on the block clock and reset
`define XPBD_ASSERT(lbl, prop) `XPBD_ASSERT_CLK(lbl, clock, reset, prop)
`else
`define XPBD_ASSERT_CLK(lbl, clk, rst, prop)
`define XPBD_ASSERT(lbl, prop)
`endif
`endif

[sv/xpbd_pkg.sv]
// shared widths, register codes and types of the xpbd distance constraint block
// no dependencies
`default_nettype none
package xpbd_pkg;
   localparam int POS_W      = 24;
   localparam int REST_W     = 24;
   localparam int LAM_W      = 32;
   localparam int CFG_W      = 32;
   localparam int STEP_W     = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int W_W        = 32;
   localparam int ALPHA_W    = 48;
   localparam int DEN_W      = 49;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COMPLIANCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP       = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0]  COMPLIANCE_RST = 32'd0;
   localparam logic [CFG_W-1:0]  MASS_RST       = 32'd65536;
   localparam logic [STEP_W-1:0] STEP_RST       = 24'd83886;

   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

   // values derived from the registers
   typedef struct packed {
      logic [W_W-1:0]     w;
      logic [ALPHA_W-1:0] alpha;
      logic [DEN_W-1:0]   den;
   } cfg_type;
endpackage
`default_nettype wire

[sv/xpbd_if.sv]
// channel interfaces of the xpbd distance constraint block
// depends on xpbd_pkg
`default_nettype none
interface xpbd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [xpbd_pkg::POS_W-1:0]   a_x;
   logic signed [xpbd_pkg::POS_W-1:0]   a_y;
   logic signed [xpbd_pkg::POS_W-1:0]   a_z;
   logic signed [xpbd_pkg::POS_W-1:0]   b_x;
   logic signed [xpbd_pkg::POS_W-1:0]   b_y;
   logic signed [xpbd_pkg::POS_W-1:0]   b_z;
   logic        [xpbd_pkg::REST_W-1:0]  rest_length;
   logic signed [xpbd_pkg::LAM_W-1:0]   multiplier_in;
   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, rest_length, multiplier_in,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, rest_length, multiplier_in,
                 output ready);
endinterface

interface xpbd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [xpbd_pkg::POS_W-1:0] new_a_x;
   logic signed [xpbd_pkg::POS_W-1:0] new_a_y;
   logic signed [xpbd_pkg::POS_W-1:0] new_a_z;
   logic signed [xpbd_pkg::POS_W-1:0] new_b_x;
   logic signed [xpbd_pkg::POS_W-1:0] new_b_y;
   logic signed [xpbd_pkg::POS_W-1:0] new_b_z;
   logic signed [xpbd_pkg::LAM_W-1:0] multiplier_out;
   modport source (output valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z,
                   multiplier_out, input ready);
   modport sink (input valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z,
                 multiplier_out, output ready);
endinterface

interface xpbd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [xpbd_pkg::CSR_IDX_W-1:0]     reg_index;
   logic [xpbd_pkg::CSR_DATA_W-1:0]    wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

[sv/xpbd_distance_constraint.sv]
// xpbd distance constraint projection: a 67-stage pipeline, one transaction per cycle while
// the result register is not held and the configuration divider is idle
// the length comes from the 25-step square root and the multiplier change from
// the 31-step division, each a register stage per bit
// reset (synchronous) empties the pipeline; after reset and after every register write the
// divider for w and alpha runs, during which no transaction is accepted
`default_nettype none
`include "xpbd_distance_constraint_macros.svh"
module xpbd_distance_constraint (
   input  logic          clock,
   input  logic          reset,
   xpbd_req_if.sink      req_ch,
   xpbd_rsp_if.source    rsp_ch,
   xpbd_csr_if.sink      csr_ch
);
   localparam int PW     = xpbd_pkg::POS_W;
   localparam int D_W    = PW + 1;
   localparam int SQ_W   = 2 * D_W - 1;
   localparam int NSQ    = D_W;
   localparam int RAD_W  = 2 * NSQ;
   localparam int REM_W  = NSQ + 2;
   localparam int LD_W   = NSQ + 1;
   localparam int NEGC_W = NSQ + 2;
   localparam int NUM_W  = 64;
   localparam int P_W    = 63;
   localparam int DEN_W  = xpbd_pkg::DEN_W;
   localparam int DR_W   = DEN_W;
   localparam int NDV    = 31;
   localparam int NNM    = 30;
   localparam int WP_W   = 63;
   localparam int SM_W   = 33;
   localparam int LW     = xpbd_pkg::LAM_W;

   localparam int I_S1   = 0;
   localparam int I_S2   = 1;
   localparam int I_SQ0  = 2;
   localparam int I_LEN  = I_SQ0 + NSQ;
   localparam int I_P1   = I_LEN + 1;
   localparam int I_P2   = I_P1 + 1;
   localparam int I_P3   = I_P2 + 1;
   localparam int I_DV0  = I_P3 + 1;
   localparam int I_DVL  = I_DV0 + NDV;
   localparam int I_E1   = I_DVL + 1;
   localparam int I_E2   = I_E1 + 1;
   localparam int I_E3   = I_E2 + 1;
   localparam int I_E4   = I_E3 + 1;
   localparam int NSTG   = I_E4 + 1;

   localparam logic [P_W-1:0]   P_CAP    = {1'b1, {(P_W - 1){1'b0}}};
   localparam logic [DEN_W-1:0] DEN_TWO  = DEN_W'(2);

   typedef struct packed {
      logic [2:0][PW-1:0]                 a;
      logic [2:0][PW-1:0]                 b;
      logic [2:0][D_W-1:0]                d;
      logic [xpbd_pkg::REST_W-1:0]        rest;
      logic [LW-1:0]                      lam;
   } base_type;

   typedef struct packed {
      base_type             base;
      logic [2:0][SQ_W-1:0] sq;
   } s2_type;

   typedef struct packed {
      base_type         base;
      logic [RAD_W-1:0] rad;
      logic [NSQ-1:0]   root;
      logic [REM_W-1:0] rem;
   } sqr_type;

   typedef struct packed {
      base_type          base;
      logic [LD_W-1:0]   lden;
      logic [NEGC_W-1:0] negc;
      logic [63:0]       prod_hi;
      logic [47:0]       prod_lo;
   } p1_type;

   typedef struct packed {
      base_type          base;
      logic [LD_W-1:0]   lden;
      logic [NEGC_W-1:0] negc;
      logic [P_W-1:0]    p;
   } p2_type;

   typedef struct packed {
      base_type         base;
      logic [LD_W-1:0]  lden;
      logic [NUM_W-1:0] num;
   } p3_type;

   typedef struct packed {
      base_type             base;
      logic [LD_W-1:0]      lden;
      logic                 neg;
      logic                 sat;
      logic [DR_W-1:0]      rem;
      logic [NDV-1:0]       dsh;
      logic [NDV-1:0]       q;
      logic [2:0][LD_W-1:0] nrem;
      logic [2:0][NNM-1:0]  nq;
   } dv_type;

   typedef struct packed {
      base_type            base;
      logic [2:0][NNM-1:0] nq;
      logic                dlneg;
      logic [LW-1:0]       lamo;
      logic [WP_W-1:0]     wprod;
   } e1_type;

   typedef struct packed {
      base_type            base;
      logic [2:0][NNM-1:0] nq;
      logic                dlneg;
      logic [LW-1:0]       lamo;
      logic [SM_W-1:0]     smag;
   } e2_type;

   typedef struct packed {
      base_type            base;
      logic                dlneg;
      logic [LW-1:0]       lamo;
      logic [2:0][SM_W-1:0] vmag;
   } e3_type;

   typedef struct packed {
      logic [2:0][PW-1:0] new_a;
      logic [2:0][PW-1:0] new_b;
      logic [LW-1:0]      lamo;
   } e4_type;

   // one digit of the square root
   function automatic sqr_type sqrt_step(input sqr_type s);
      sqr_type            r;
      logic [REM_W+1:0]   t;
      logic [REM_W+1:0]   trial;
      r     = s;
      t     = {s.rem, s.rad[RAD_W-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      if (t >= trial) begin
         r.rem  = REM_W'(t - trial);
         r.root = {s.root[NSQ-2:0], 1'b1};
      end else begin
         r.rem  = t[REM_W-1:0];
         r.root = {s.root[NSQ-2:0], 1'b0};
      end
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      return r;
   endfunction

   // one quotient bit of the multiplier division and of the three direction divisions
   function automatic dv_type dv_step(input dv_type s, input logic [DEN_W-1:0] den,
                                      input logic do_dir);
      dv_type          r;
      logic [DR_W:0]   t;
      logic            ge;
      logic [LD_W:0]   tn;
      logic            gn;
      r  = s;
      t  = {s.rem, s.dsh[NDV-1]};
      ge = t >= {1'b0, den};
      r.rem = ge ? DR_W'(t - {1'b0, den}) : t[DR_W-1:0];
      r.q   = {s.q[NDV-2:0], ge};
      r.dsh = {s.dsh[NDV-2:0], 1'b0};
      if (do_dir) begin
         for (int i = 0; i < 3; i++) begin
            tn = {s.nrem[i], 1'b0};
            gn = tn >= {1'b0, s.lden};
            r.nrem[i] = gn ? LD_W'(tn - {1'b0, s.lden}) : tn[LD_W-1:0];
            r.nq[i]   = {s.nq[i][NNM-2:0], gn};
         end
      end
      return r;
   endfunction

   // saturate a 36-bit two's complement sum to a position
   function automatic logic [PW-1:0] sat_pos(input logic [PW+11:0] x);
      logic [PW-1:0] r;
      if (x[PW+11:PW-1] == '0 || x[PW+11:PW-1] == '1) begin
         r = x[PW-1:0];
      end else begin
         r = x[PW+11] ? {1'b1, {(PW - 1){1'b0}}} : {1'b0, {(PW - 1){1'b1}}};
      end
      return r;
   endfunction

   xpbd_pkg::csr_wr_type csr_wr;
   xpbd_pkg::cfg_type    cfg;
   logic                 cfg_busy;

   logic            en;
   logic            accept;
   logic [NSTG-1:0] vld_ff, vld_in;

   base_type s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   sqr_type  sqr_ff [0:NSQ];
   sqr_type  sqr_in [0:NSQ];
   p1_type   p1_ff, p1_in;
   p2_type   p2_ff, p2_in;
   p3_type   p3_ff, p3_in;
   dv_type   dv_ff [0:NDV];
   dv_type   dv_in [0:NDV];
   e1_type   e1_ff, e1_in;
   e2_type   e2_ff, e2_in;
   e3_type   e3_ff, e3_in;
   e4_type   e4_ff, e4_in;

   logic signed [2*D_W-1:0] sqp [0:2];
   logic [LW-1:0]           mlam;
   logic [63:0]             psum;
   logic [NUM_W-1:0]        negc_x;
   logic [NUM_W-1:0]        num_neg;
   logic [P_W-1:0]          nabs;
   logic [D_W-1:0]          dabs;
   logic [NDV-1:0]          dmag;
   logic                    dlneg;
   logic [LW:0]             dl_x;
   logic [LW:0]             lsum;
   logic [63:0]             vprod [0:2];
   logic [PW+11:0]          v_x;
   logic                    vneg;

   // configuration registers and derived constants
   assign csr_wr = '{we: csr_ch.valid && csr_ch.ready, idx: csr_ch.reg_index,
                     data: csr_ch.wdata};
   assign csr_ch.ready = 1'b1;

   xpbd_cfg u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .cfg    (cfg),
      .busy   (cfg_busy)
   );

   // handshake: the whole pipeline moves unless the result register is held
   assign en           = !vld_ff[I_E4] || rsp_ch.ready;
   assign req_ch.ready = en && !cfg_busy;
   assign accept       = req_ch.valid && req_ch.ready;
   assign vld_in       = {vld_ff[NSTG-2:0], accept};

   // separation per axis
   always_comb begin
      s1_in.a    = {req_ch.a_z, req_ch.a_y, req_ch.a_x};
      s1_in.b    = {req_ch.b_z, req_ch.b_y, req_ch.b_x};
      s1_in.rest = req_ch.rest_length;
      s1_in.lam  = req_ch.multiplier_in;
      for (int i = 0; i < 3; i++) begin
         s1_in.d[i] = {s1_in.a[i][PW-1], s1_in.a[i]} - {s1_in.b[i][PW-1], s1_in.b[i]};
      end
   end

   // squares
   always_comb begin
      s2_in.base = s1_ff;
      for (int i = 0; i < 3; i++) begin
         sqp[i]      = $signed(s1_ff.d[i]) * $signed(s1_ff.d[i]);
         s2_in.sq[i] = sqp[i][SQ_W-1:0];
      end
   end

   // squared length seeds the root
   always_comb begin
      sqr_in[0].base = s2_ff.base;
      sqr_in[0].rad  = RAD_W'(s2_ff.sq[0]) + RAD_W'(s2_ff.sq[1]) + RAD_W'(s2_ff.sq[2]);
      sqr_in[0].root = '0;
      sqr_in[0].rem  = '0;
   end

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      assign sqr_in[k+1] = sqrt_step(sqr_ff[k]);
   end

   // constraint value and multiplier times alpha, partial products
   always_comb begin
      mlam          = sqr_ff[NSQ].base.lam[LW-1] ? (~sqr_ff[NSQ].base.lam + 1'b1)
                                                 : sqr_ff[NSQ].base.lam;
      p1_in.base    = sqr_ff[NSQ].base;
      p1_in.lden    = {1'b0, sqr_ff[NSQ].root} + 1'b1;
      p1_in.negc    = NEGC_W'(sqr_ff[NSQ].base.rest) - NEGC_W'(sqr_ff[NSQ].root);
      p1_in.prod_hi = 64'(mlam) * 64'(cfg.alpha[47:16]);
      p1_in.prod_lo = 48'(mlam) * 48'(cfg.alpha[15:0]);
   end

   // sum of partial products, capped
   always_comb begin
      psum       = p1_ff.prod_hi + 64'(p1_ff.prod_lo[47:16]);
      p2_in.base = p1_ff.base;
      p2_in.lden = p1_ff.lden;
      p2_in.negc = p1_ff.negc;
      p2_in.p    = (psum > 64'(P_CAP)) ? P_CAP : psum[P_W-1:0];
   end

   // numerator of the multiplier change
   always_comb begin
      negc_x     = {{(NUM_W - NEGC_W){p2_ff.negc[NEGC_W-1]}}, p2_ff.negc};
      p3_in.base = p2_ff.base;
      p3_in.lden = p2_ff.lden;
      p3_in.num  = p2_ff.base.lam[LW-1] ? (negc_x + {1'b0, p2_ff.p})
                                        : (negc_x - {1'b0, p2_ff.p});
   end

   // magnitude, saturation test and division seeds
   always_comb begin
      num_neg        = -p3_ff.num;
      nabs           = p3_ff.num[NUM_W-1] ? num_neg[P_W-1:0] : p3_ff.num[P_W-1:0];
      dv_in[0].base  = p3_ff.base;
      dv_in[0].lden  = p3_ff.lden;
      dv_in[0].neg   = p3_ff.num[NUM_W-1];
      dv_in[0].sat   = {1'b0, nabs} >= {cfg.den, 15'b0};
      dv_in[0].rem   = DR_W'(nabs[P_W-1:15]);
      dv_in[0].dsh   = {nabs[14:0], 16'b0};
      dv_in[0].q     = '0;
      dv_in[0].nq    = '0;
      dabs           = '0;
      for (int i = 0; i < 3; i++) begin
         dabs = p3_ff.base.d[i][D_W-1] ? (~p3_ff.base.d[i] + 1'b1) : p3_ff.base.d[i];
         dv_in[0].nrem[i] = LD_W'(dabs);
      end
   end

   for (genvar k = 0; k < NDV; k++) begin : g_div
      assign dv_in[k+1] = dv_step(dv_ff[k], cfg.den, 1'(k < NNM));
   end

   // multiplier update and step scale
   always_comb begin
      dmag        = dv_ff[NDV].sat ? '1 : dv_ff[NDV].q;
      dlneg       = dv_ff[NDV].neg && (dmag != '0);
      dl_x        = dlneg ? (~{2'b00, dmag} + 1'b1) : {2'b00, dmag};
      lsum        = {dv_ff[NDV].base.lam[LW-1], dv_ff[NDV].base.lam} + dl_x;
      e1_in.base  = dv_ff[NDV].base;
      e1_in.nq    = dv_ff[NDV].nq;
      e1_in.dlneg = dlneg;
      if (lsum[LW] != lsum[LW-1]) begin
         e1_in.lamo = lsum[LW] ? {1'b1, {(LW - 1){1'b0}}} : {1'b0, {(LW - 1){1'b1}}};
      end else begin
         e1_in.lamo = lsum[LW-1:0];
      end
      e1_in.wprod = WP_W'(cfg.w) * WP_W'(dmag);
   end

   // scaled step, capped
   always_comb begin
      e2_in.base  = e1_ff.base;
      e2_in.nq    = e1_ff.nq;
      e2_in.dlneg = e1_ff.dlneg;
      e2_in.lamo  = e1_ff.lamo;
      e2_in.smag  = (e1_ff.wprod[WP_W-1:SM_W+16] != '0) ? '1 : e1_ff.wprod[SM_W+15:16];
   end

   // move magnitude per axis
   always_comb begin
      e3_in.base  = e2_ff.base;
      e3_in.dlneg = e2_ff.dlneg;
      e3_in.lamo  = e2_ff.lamo;
      for (int i = 0; i < 3; i++) begin
         vprod[i]      = 64'(e2_ff.smag) * 64'(e2_ff.nq[i]);
         e3_in.vmag[i] = vprod[i][SM_W+29:30];
      end
   end

   // apply the moves and saturate
   always_comb begin
      e4_in.lamo = e3_ff.lamo;
      v_x        = '0;
      vneg       = 1'b0;
      for (int i = 0; i < 3; i++) begin
         vneg = e3_ff.dlneg != e3_ff.base.d[i][D_W-1];
         v_x  = vneg ? (~{{(PW + 12 - SM_W){1'b0}}, e3_ff.vmag[i]} + 1'b1)
                     : {{(PW + 12 - SM_W){1'b0}}, e3_ff.vmag[i]};
         e4_in.new_a[i] = sat_pos({{12{e3_ff.base.a[i][PW-1]}}, e3_ff.base.a[i]} + v_x);
         e4_in.new_b[i] = sat_pos({{12{e3_ff.base.b[i][PW-1]}}, e3_ff.base.b[i]} - v_x);
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         e3_ff <= e3_in;
         e4_ff <= e4_in;
      end
   end

   for (genvar k = 0; k <= NSQ; k++) begin : g_sqrt_reg
      always_ff @(posedge clock) begin
         if (en) begin
            sqr_ff[k] <= sqr_in[k];
         end
      end
   end

   for (genvar k = 0; k <= NDV; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // result transaction
   assign rsp_ch.valid          = vld_ff[I_E4];
   assign rsp_ch.new_a_x        = e4_ff.new_a[0];
   assign rsp_ch.new_a_y        = e4_ff.new_a[1];
   assign rsp_ch.new_a_z        = e4_ff.new_a[2];
   assign rsp_ch.new_b_x        = e4_ff.new_b[0];
   assign rsp_ch.new_b_y        = e4_ff.new_b[1];
   assign rsp_ch.new_b_z        = e4_ff.new_b[2];
   assign rsp_ch.multiplier_out = e4_ff.lamo;

   // checks
   `XPBD_ASSERT(a_stall_holds_pipe, (vld_ff[I_E4] && !rsp_ch.ready) |=> $stable(vld_ff))
   `XPBD_ASSERT(a_sqrt_rem_bound, vld_ff[I_LEN] |-> (sqr_ff[NSQ].rem <= {sqr_ff[NSQ].root, 1'b0}))
   `XPBD_ASSERT(a_den_nonzero, !cfg_busy |-> (cfg.den >= DEN_TWO))
endmodule
`default_nettype wire

[sv/xpbd_cfg.sv]
// configuration registers and the sequential divider that derives w, alpha and 2w + alpha
// depends on xpbd_pkg
`default_nettype none
module xpbd_cfg (
   input  logic                 clock,
   input  logic                 reset,
   input  xpbd_pkg::csr_wr_type csr_wr,
   output xpbd_pkg::cfg_type    cfg,
   output logic                 busy
);
   localparam int DIV_N = xpbd_pkg::CFG_W + xpbd_pkg::ALPHA_W + 1;
   localparam int CNT_W = $clog2(DIV_N);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N - 1);
   localparam int AW = xpbd_pkg::ALPHA_W;
   localparam int WW = xpbd_pkg::W_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SQUARE = 2'd1;
   localparam logic [1:0] ST_DIV_W  = 2'd2;
   localparam logic [1:0] ST_DIV_A  = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [xpbd_pkg::CFG_W-1:0]     compliance_ff, compliance_in;
   logic [xpbd_pkg::CFG_W-1:0]     mass_ff, mass_in;
   logic [xpbd_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [AW-1:0]                  tsq_ff, tsq_in;
   logic [DIV_N-1:0]               num_ff, num_in;
   logic [AW-1:0]                  rem_ff, rem_in;
   logic [AW-1:0]                  q_ff, q_in;
   logic                           ovf_ff, ovf_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [WW-1:0]                  w_ff, w_in;
   logic [AW-1:0]                  alpha_ff, alpha_in;
   logic [xpbd_pkg::DEN_W-1:0]     den_ff, den_in;

   logic [AW-1:0] den_cur;
   logic [AW:0]   rem_sh;
   logic          ge;
   logic [AW-1:0] rem_nx;
   logic [AW-1:0] q_nx;
   logic          ovf_nx;
   logic [WW-1:0] w_val;
   logic [AW-1:0] alpha_val;

   // one restoring division step, quotient bits above the cap fold into an overflow flag
   always_comb begin
      den_cur   = (state_ff == ST_DIV_W) ? AW'(mass_ff) : tsq_ff;
      rem_sh    = {rem_ff, num_ff[DIV_N-1]};
      ge        = rem_sh >= {1'b0, den_cur};
      rem_nx    = ge ? AW'(rem_sh - {1'b0, den_cur}) : rem_sh[AW-1:0];
      q_nx      = {q_ff[AW-2:0], ge};
      ovf_nx    = ovf_ff | q_ff[AW-1];
      w_val     = (mass_ff == '0 || ovf_nx || q_nx[AW-1:WW] != '0) ? '1 : q_nx[WW-1:0];
      alpha_val = (tsq_ff == '0 || ovf_nx) ? '1 : q_nx;
   end

   // sequencer: square step time, divide for w, divide for alpha
   always_comb begin
      state_in      = state_ff;
      compliance_in = compliance_ff;
      mass_in       = mass_ff;
      step_in       = step_ff;
      tsq_in        = tsq_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      ovf_in        = ovf_ff;
      cnt_in        = cnt_ff;
      w_in          = w_ff;
      alpha_in      = alpha_ff;
      den_in        = den_ff;
      case (state_ff)
         ST_SQUARE: begin
            tsq_in   = step_ff * step_ff;
            num_in   = {{(DIV_N - WW - 1){1'b0}}, 1'b1, {WW{1'b0}}};
            rem_in   = '0;
            q_in     = '0;
            ovf_in   = 1'b0;
            cnt_in   = '0;
            state_in = ST_DIV_W;
         end
         ST_DIV_W: begin
            num_in = {num_ff[DIV_N-2:0], 1'b0};
            rem_in = rem_nx;
            q_in   = q_nx;
            ovf_in = ovf_nx;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               w_in     = w_val;
               num_in   = {1'b0, compliance_ff, {AW{1'b0}}};
               rem_in   = '0;
               q_in     = '0;
               ovf_in   = 1'b0;
               cnt_in   = '0;
               state_in = ST_DIV_A;
            end
         end
         ST_DIV_A: begin
            num_in = {num_ff[DIV_N-2:0], 1'b0};
            rem_in = rem_nx;
            q_in   = q_nx;
            ovf_in = ovf_nx;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               alpha_in = alpha_val;
               den_in   = xpbd_pkg::DEN_W'({w_ff, 1'b0}) + xpbd_pkg::DEN_W'(alpha_val);
               state_in = ST_IDLE;
            end
         end
         default: begin
         end
      endcase
      // a register write restarts the derivation
      if (csr_wr.we) begin
         case (csr_wr.idx)
            xpbd_pkg::CSR_COMPLIANCE: compliance_in = csr_wr.data;
            xpbd_pkg::CSR_MASS:       mass_in       = csr_wr.data;
            xpbd_pkg::CSR_STEP:       step_in       = csr_wr.data[xpbd_pkg::STEP_W-1:0];
            default: begin
            end
         endcase
         state_in = ST_SQUARE;
      end
   end

   // control and register state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SQUARE;
         compliance_ff <= xpbd_pkg::COMPLIANCE_RST;
         mass_ff       <= xpbd_pkg::MASS_RST;
         step_ff       <= xpbd_pkg::STEP_RST;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         compliance_ff <= compliance_in;
         mass_ff       <= mass_in;
         step_ff       <= step_in;
         cnt_ff        <= cnt_in;
      end
   end

   // divider datapath
   always_ff @(posedge clock) begin
      tsq_ff   <= tsq_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      ovf_ff   <= ovf_in;
      w_ff     <= w_in;
      alpha_ff <= alpha_in;
      den_ff   <= den_in;
   end

   assign cfg  = '{w: w_ff, alpha: alpha_ff, den: den_ff};
   assign busy = state_ff != ST_IDLE;
endmodule
`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the xpbd distance constraint projection block
// depends on xpbd_pkg, the channel interfaces in xpbd_if.sv and the block itself
`timescale 1ns / 1ps
module tb_top;
   localparam int PW = xpbd_pkg::POS_W;
   localparam int RW = xpbd_pkg::REST_W;
   localparam int LW = xpbd_pkg::LAM_W;
   localparam int IW = xpbd_pkg::CSR_IDX_W;
   localparam int DW = xpbd_pkg::CSR_DATA_W;
   localparam int SW = xpbd_pkg::STEP_W;

   localparam logic [IW-1:0] CSR_SPARE = IW'(3);
   localparam int DRAIN_CYCLES = 100;
   localparam longint POS_HI = 64'sd8388607;
   localparam longint POS_LO = -64'sd8388608;
   localparam longint LAM_HI = 64'sd2147483647;
   localparam longint LAM_LO = -64'sd2147483648;

   typedef struct {
      logic signed [PW-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
      logic [RW-1:0]        rest_length;
      logic signed [LW-1:0] multiplier_in;
   } edge_item_type;

   typedef struct {
      logic signed [PW-1:0] pos [6];
      logic signed [LW-1:0] multiplier_out;
   } projection_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xpbd_req_if req_ch ();
   xpbd_rsp_if rsp_ch ();
   xpbd_csr_if csr_ch ();

   xpbd_distance_constraint u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // register mirror
   longint unsigned compliance_q = 64'(xpbd_pkg::COMPLIANCE_RST);
   longint unsigned mass_q       = 64'(xpbd_pkg::MASS_RST);
   longint unsigned step_q       = 64'(xpbd_pkg::STEP_RST);

   edge_item_type  edge_queue [$];
   projection_type projection_queue [$];
   edge_item_type  held_edge;
   int             error_count = 0;
   int             send_gap = 0;
   int             recv_gap = 0;
   bit             calm = 1'b0;
   string          pos_name [6] = '{"new_a_x", "new_a_y", "new_a_z",
                                    "new_b_x", "new_b_y", "new_b_z"};

   // floor(num * 2^fb / den), saturated to cap
   function automatic longint unsigned div_fix(longint unsigned num, longint unsigned den,
                                               int fb, longint unsigned cap);
      longint unsigned q, r;
      if (den == 0) return cap;
      q = num / den;
      r = num % den;
      if (q > cap) return cap;
      for (int i = 0; i < fb; i++) begin
         if (q > (cap >> 1)) return cap;
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint unsigned abs64(longint x);
      return (x < 0) ? longint'(-x) : longint'(x);
   endfunction

   function automatic longint sat(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // one projection of an edge under the mirrored registers
   function automatic projection_type project_edge(edge_item_type e);
      longint pa [3], pb [3], dd [3];
      longint lam, negc, num, dl, v;
      longint unsigned sum, len, w, tt, alpha, mlam, p, den, dmag, smag, lden, nm;
      projection_type r;
      pa[0] = e.a_x; pa[1] = e.a_y; pa[2] = e.a_z;
      pb[0] = e.b_x; pb[1] = e.b_y; pb[2] = e.b_z;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         dd[i] = pa[i] - pb[i];
         sum = sum + longint'(dd[i] * dd[i]);
      end
      lam = e.multiplier_in;
      len = int_sqrt(sum);
      negc = longint'({40'd0, e.rest_length}) - longint'(len);
      w = div_fix(64'd65536, mass_q, 16, 64'hFFFF_FFFF);
      tt = step_q;
      alpha = div_fix(compliance_q, tt * tt, 48, (64'd1 << 48) - 1);
      mlam = abs64(lam);
      p = mlam * (alpha >> 16) + ((mlam * (alpha & 64'hFFFF)) >> 16);
      if (p > (64'd1 << 62)) p = 64'd1 << 62;
      num = (lam < 0) ? negc + longint'(p) : negc - longint'(p);
      den = 2 * w + alpha;
      dmag = div_fix(abs64(num), den, 16, 64'h7FFF_FFFF);
      dl = (num < 0) ? -longint'(dmag) : longint'(dmag);
      r.multiplier_out = LW'(sat(lam + dl, LAM_LO, LAM_HI));
      smag = (w * dmag) >> 16;
      if (smag > (64'd1 << 33) - 1) smag = (64'd1 << 33) - 1;
      lden = len + 1;
      for (int i = 0; i < 3; i++) begin
         nm = (abs64(dd[i]) << 30) / lden;
         v = longint'((smag * nm) >> 30);
         if ((dl < 0) != (dd[i] < 0)) v = -v;
         r.pos[i]     = PW'(sat(pa[i] + v, POS_LO, POS_HI));
         r.pos[i + 3] = PW'(sat(pb[i] - v, POS_LO, POS_HI));
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // append to the pending queue
   function automatic void add_edge(edge_item_type e);
      edge_queue.insert(edge_queue.size(), e);
   endfunction

   // mostly short gaps, a few long ones, none while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if ($urandom_range(0, 149) == 0) calm <= ($urandom_range(0, 3) == 0);
   end

   // driver: request channel
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            projection_queue.insert(projection_queue.size(), project_edge(held_edge));
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (edge_queue.size() > 0) begin
            held_edge = edge_queue.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.a_x           <= held_edge.a_x;
            req_ch.a_y           <= held_edge.a_y;
            req_ch.a_z           <= held_edge.a_z;
            req_ch.b_x           <= held_edge.b_x;
            req_ch.b_y           <= held_edge.b_y;
            req_ch.b_z           <= held_edge.b_z;
            req_ch.rest_length   <= held_edge.rest_length;
            req_ch.multiplier_in <= held_edge.multiplier_in;
            send_gap <= pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: result channel
   always @(posedge clock) begin
      projection_type       want;
      logic signed [PW-1:0] got_pos [6];
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_pos[0] = rsp_ch.new_a_x;
            got_pos[1] = rsp_ch.new_a_y;
            got_pos[2] = rsp_ch.new_a_z;
            got_pos[3] = rsp_ch.new_b_x;
            got_pos[4] = rsp_ch.new_b_y;
            got_pos[5] = rsp_ch.new_b_z;
            if (projection_queue.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = projection_queue.pop_front();
               for (int i = 0; i < 6; i++) begin
                  if (got_pos[i] !== want.pos[i])
                     report_mismatch(pos_name[i], got_pos[i], want.pos[i]);
               end
               if (rsp_ch.multiplier_out !== want.multiplier_out)
                  report_mismatch("multiplier_out", rsp_ch.multiplier_out, want.multiplier_out);
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            recv_gap <= pick_gap();
         end
      end
   end

   task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] data);
      @(posedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata     <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         xpbd_pkg::CSR_COMPLIANCE: compliance_q = 64'(data);
         xpbd_pkg::CSR_MASS:       mass_q = 64'(data);
         xpbd_pkg::CSR_STEP:       step_q = 64'(data[SW-1:0]);
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (edge_queue.size() != 0 || req_ch.valid || projection_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic edge_item_type make_edge(int ax, int ay, int az, int bx, int by, int bz,
                                               int rest, int lam);
      edge_item_type e;
      e.a_x = PW'(ax); e.a_y = PW'(ay); e.a_z = PW'(az);
      e.b_x = PW'(bx); e.b_y = PW'(by); e.b_z = PW'(bz);
      e.rest_length = RW'(rest);
      e.multiplier_in = LW'(lam);
      return e;
   endfunction

   // mostly nearby pairs with a rest length close to their spacing, some raw noise
   function automatic edge_item_type random_edge();
      edge_item_type e;
      int ax, ay, az, span;
      if ($urandom_range(0, 9) < 6) begin
         ax = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
         ay = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
         az = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
         span = 2 ** $urandom_range(4, 18);
         e = make_edge(ax, ay, az,
                       ax + $signed($urandom_range(0, 2 * span)) - span,
                       ay + $signed($urandom_range(0, 2 * span)) - span,
                       az + $signed($urandom_range(0, 2 * span)) - span,
                       $urandom_range(0, 2 * span),
                       ($urandom_range(0, 3) == 0) ? $urandom() :
                          $signed($urandom_range(0, 2 ** 18)) - 2 ** 17);
      end else begin
         e = make_edge($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom());
      end
      return e;
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.a_x = '0; req_ch.a_y = '0; req_ch.a_z = '0;
      req_ch.b_x = '0; req_ch.b_y = '0; req_ch.b_z = '0;
      req_ch.rest_length = '0;
      req_ch.multiplier_in = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.reg_index = xpbd_pkg::CSR_COMPLIANCE;
      csr_ch.wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed edges under reset register values
      add_edge(make_edge(0, 0, 0, 0, 0, 0, 0, 0));
      add_edge(make_edge(0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0));
      add_edge(make_edge(5, -7, 9, 5, -7, 9, 65536, 32'h7FFFFFFF));
      add_edge(make_edge(5, -7, 9, 5, -7, 9, 65536, 32'h80000000));
      add_edge(make_edge(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 0, 0));
      add_edge(make_edge(-8388608, -8388608, -8388608,
                         8388607, 8388607, 8388607, 24'hFFFFFF, 32'h7FFFFFFF));
      add_edge(make_edge(8388607, 0, 0, -8388608, 0, 0, 24'hFFFFFF, 32'h80000000));
      add_edge(make_edge(65536, 0, 0, 0, 0, 0, 65536, 0));
      add_edge(make_edge(0, 65536, 0, 0, 0, 0, 131072, 0));
      add_edge(make_edge(0, 0, -65536, 0, 0, 0, 32768, -65536));
      add_edge(make_edge(1, 0, 0, 0, 0, 0, 0, 0));
      add_edge(make_edge(0, 0, 0, 0, 0, 1, 24'hFFFFFF, 1));
      add_edge(make_edge(8388607, 8388607, 8388607, 8388600, 8388600, 8388600,
                         24'hFFFFFF, 32'h7FFFFFFF));
      add_edge(make_edge(-8388608, -8388608, -8388608, -8388600, -8388600, -8388600,
                         24'hFFFFFF, 32'h80000000));
      add_edge(make_edge(100000, -200000, 300000, -100000, 200000, -300000, 1000, 12345));
      for (int i = 0; i < 300; i++) add_edge(random_edge());
      wait_idle();

      // sweep register settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(xpbd_pkg::CSR_COMPLIANCE, 32'd1000);
               write_reg(xpbd_pkg::CSR_MASS, 32'd65536);
               write_reg(xpbd_pkg::CSR_STEP, 32'd83886);
            end
            1: begin
               write_reg(xpbd_pkg::CSR_COMPLIANCE, 32'hFFFFFFFF);
               write_reg(xpbd_pkg::CSR_MASS, 32'd1);
               write_reg(xpbd_pkg::CSR_STEP, 32'd1);
            end
            2: begin
               write_reg(xpbd_pkg::CSR_COMPLIANCE, 32'd0);
               write_reg(xpbd_pkg::CSR_MASS, 32'hFFFFFFFF);
               write_reg(xpbd_pkg::CSR_STEP, 32'hFFFFFFFF);
            end
            3: begin
               // zero mass and zero step time, then a write to the spare index
               write_reg(xpbd_pkg::CSR_COMPLIANCE, 32'd65536);
               write_reg(xpbd_pkg::CSR_MASS, 32'd0);
               write_reg(xpbd_pkg::CSR_STEP, 32'd0);
               write_reg(CSR_SPARE, $urandom());
            end
            default: begin
               write_reg(xpbd_pkg::CSR_COMPLIANCE, $urandom_range(0, 2 ** 20));
               write_reg(xpbd_pkg::CSR_MASS, $urandom());
               write_reg(xpbd_pkg::CSR_STEP, $urandom());
            end
         endcase
         add_edge(make_edge(0, 0, 0, 0, 0, 0, 65536, 32'h7FFFFFFF));
         add_edge(make_edge(8388607, -8388608, 0, -8388608, 8388607, 0, 0, 32'h80000000));
         for (int i = 0; i < 270; i++) add_edge(random_edge());
         wait_idle();
      end

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
